// File: rtl/stq_pkg.sv
// shared types, codes and constants of the sorted timer event queue
package stq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_HANDLES     = 16;
    localparam int HANDLE_W        = 4;
    localparam int CMD_W           = 2;
    localparam int KIND_W          = 3;
    localparam int DELAY_W         = 32;
    localparam int TAG_W           = 16;
    localparam int TIME_W          = 64;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DROP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_INSERTED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUEUE_FULL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DROPPED    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIRED      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE  = 3'd5;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_DROP,
        OP_FIRE
    } op_t;

    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   deadline;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        op_t                 op;
        logic [TIME_W-1:0]   deadline;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
        logic [HANDLE_W-1:0] drop_handle;
    } cell_ctrl_t;

endpackage

// File: rtl/stq_req_if.sv
// request channel of the sorted timer event queue
interface stq_req_if;
    logic                           valid;
    logic                           ready;
    logic [stq_pkg::CMD_W-1:0]      cmd;
    logic [stq_pkg::DELAY_W-1:0]    delay;
    logic [stq_pkg::TAG_W-1:0]      event_tag;
    logic [stq_pkg::HANDLE_W-1:0]   drop_handle;

    modport source (output valid, output cmd, output delay, output event_tag,
                    output drop_handle, input ready);
    modport sink   (input valid, input cmd, input delay, input event_tag,
                    input drop_handle, output ready);
endinterface

// File: rtl/stq_rsp_if.sv
// response channel of the sorted timer event queue
interface stq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [stq_pkg::KIND_W-1:0]     kind;
    logic [stq_pkg::HANDLE_W-1:0]   handle;
    logic [stq_pkg::TAG_W-1:0]      fired_tag;
    logic [stq_pkg::TIME_W-1:0]     time_now;
    logic                           last;

    modport source (output valid, output kind, output handle, output fired_tag,
                    output time_now, output last, input ready);
    modport sink   (input valid, input kind, input handle, input fired_tag,
                    input time_now, input last, output ready);
endinterface

// File: rtl/stq_cell.sv
// one queue cell: holds one event and trades it with its neighbors
module stq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  stq_pkg::cell_ctrl_t ctrl,
    input  stq_pkg::entry_t     left_entry,
    input  logic                left_hit,
    input  logic                left_after,
    input  stq_pkg::entry_t     right_entry,
    output stq_pkg::entry_t     entry,
    output logic                hit,
    output logic                after
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [stq_pkg::TIME_W-1:0]    deadline_reg;
    logic [stq_pkg::TIME_W-1:0]    deadline_next;
    logic [stq_pkg::TAG_W-1:0]     tag_reg;
    logic [stq_pkg::TAG_W-1:0]     tag_next;
    logic [stq_pkg::HANDLE_W-1:0]  handle_reg;
    logic [stq_pkg::HANDLE_W-1:0]  handle_next;
    logic                          take_left;
    logic                          take_new;
    logic                          take_right;

    assign entry.valid    = valid_reg;
    assign entry.deadline = deadline_reg;
    assign entry.tag      = tag_reg;
    assign entry.handle   = handle_reg;

    // insert point: first cell that is empty or not earlier than the new deadline
    assign hit   = !valid_reg || (ctrl.deadline <= deadline_reg);
    assign after = left_after || (valid_reg && (handle_reg == ctrl.drop_handle));

    always_comb
    begin
        take_left  = 1'b0;
        take_new   = 1'b0;
        take_right = 1'b0;
        unique case (ctrl.op)
            stq_pkg::OP_NONE:
            begin
                take_left = 1'b0;
            end
            stq_pkg::OP_INSERT:
            begin
                take_left = left_hit;
                take_new  = !left_hit && hit;
            end
            stq_pkg::OP_DROP:
            begin
                take_right = after;
            end
            stq_pkg::OP_FIRE:
            begin
                take_right = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        tag_next      = tag_reg;
        handle_next   = handle_reg;
        priority if (take_left)
        begin
            valid_next    = left_entry.valid;
            deadline_next = left_entry.deadline;
            tag_next      = left_entry.tag;
            handle_next   = left_entry.handle;
        end
        else if (take_new)
        begin
            valid_next    = 1'b1;
            deadline_next = ctrl.deadline;
            tag_next      = ctrl.tag;
            handle_next   = ctrl.handle;
        end
        else if (take_right)
        begin
            valid_next    = right_entry.valid;
            deadline_next = right_entry.deadline;
            tag_next      = right_entry.tag;
            handle_next   = right_entry.handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        tag_reg      <= tag_next;
        handle_reg   <= handle_next;
    end

endmodule

// File: rtl/sorted_timer_event_queue.sv
// sorted timer event queue: tick counter and a deadline-sorted chain of event cells
// insert and drop: the request is registered, then the chain is updated and the
// response register loaded once it is free; a new request is taken only in idle
// tick: count incremented, then one fired event per cycle from the head cell while
// the response register is free, then the tick-done transfer
// reset clears the tick count, all cell valid bits and the handle map at once
module sorted_timer_event_queue #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    stq_req_if.sink   req,
    stq_rsp_if.source rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_FIRE = 2'd2;

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [stq_pkg::TIME_W-1:0]      now_reg;
    logic [stq_pkg::TIME_W-1:0]      now_next;
    logic [stq_pkg::CMD_W-1:0]       cmd_reg;
    logic [stq_pkg::TIME_W-1:0]      dl_reg;
    logic [stq_pkg::TAG_W-1:0]       tag_reg;
    logic [stq_pkg::HANDLE_W-1:0]    dh_reg;
    logic [stq_pkg::NUM_HANDLES-1:0] in_use_reg;
    logic [stq_pkg::NUM_HANDLES-1:0] in_use_next;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [stq_pkg::KIND_W-1:0]      out_kind_reg;
    logic [stq_pkg::KIND_W-1:0]      out_kind_next;
    logic [stq_pkg::HANDLE_W-1:0]    out_handle_reg;
    logic [stq_pkg::HANDLE_W-1:0]    out_handle_next;
    logic [stq_pkg::TAG_W-1:0]       out_tag_reg;
    logic [stq_pkg::TAG_W-1:0]       out_tag_next;
    logic [stq_pkg::TIME_W-1:0]      out_time_reg;
    logic [stq_pkg::TIME_W-1:0]      out_time_next;
    logic                            out_last_reg;
    logic                            out_last_next;

    logic                            req_fire;
    logic                            out_free;
    logic                            full;
    logic                            found;
    logic                            head_due;
    logic [stq_pkg::HANDLE_W-1:0]    free_handle;
    stq_pkg::op_t                    ctrl_op;
    stq_pkg::cell_ctrl_t             ctrl;
    stq_pkg::entry_t                 cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]          cell_hit;
    logic [QUEUE_DEPTH-1:0]          cell_after;
    logic [QUEUE_DEPTH-1:0]          valid_vec;

    function automatic logic [stq_pkg::HANDLE_W-1:0] lowest_free(
        input logic [stq_pkg::NUM_HANDLES-1:0] used
    );
        logic [stq_pkg::HANDLE_W-1:0] h;
        h = '0;
        for (int i = stq_pkg::NUM_HANDLES - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                h = stq_pkg::HANDLE_W'(i);
            end
        end
        return h;
    endfunction

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            stq_pkg::entry_t left_entry;
            stq_pkg::entry_t right_entry;
            logic            left_hit;
            logic            left_after;

            if (gi == 0)
            begin : g_first
                assign left_entry = '0;
                assign left_hit   = 1'b0;
                assign left_after = 1'b0;
            end
            else
            begin : g_mid
                assign left_entry = cell_entry[gi-1];
                assign left_hit   = cell_hit[gi-1];
                assign left_after = cell_after[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_entry = '0;
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[gi+1];
            end

            stq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_entry  (left_entry),
                .left_hit    (left_hit),
                .left_after  (left_after),
                .right_entry (right_entry),
                .entry       (cell_entry[gi]),
                .hit         (cell_hit[gi]),
                .after       (cell_after[gi])
            );

            assign valid_vec[gi] = cell_entry[gi].valid;
        end
    endgenerate

    assign req.ready   = (state_reg == ST_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign full        = valid_vec[QUEUE_DEPTH-1] || (&in_use_reg);
    assign found       = cell_after[QUEUE_DEPTH-1];
    assign head_due    = cell_entry[0].valid && (now_reg >= cell_entry[0].deadline);
    assign free_handle = lowest_free(in_use_reg);

    assign ctrl.op          = ctrl_op;
    assign ctrl.deadline    = dl_reg;
    assign ctrl.tag         = tag_reg;
    assign ctrl.handle      = free_handle;
    assign ctrl.drop_handle = dh_reg;

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        in_use_next     = in_use_reg;
        ctrl_op         = stq_pkg::OP_NONE;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_kind_next   = out_kind_reg;
        out_handle_next = out_handle_reg;
        out_tag_next    = out_tag_reg;
        out_time_next   = out_time_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.cmd == stq_pkg::CMD_TICK)
                    begin
                        now_next   = now_reg + stq_pkg::TIME_W'(1);
                        state_next = ST_FIRE;
                    end
                    else if (req.cmd == stq_pkg::CMD_INSERT || req.cmd == stq_pkg::CMD_DROP)
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_tag_next   = '0;
                    out_time_next  = now_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                    if (cmd_reg == stq_pkg::CMD_INSERT)
                    begin
                        if (full)
                        begin
                            out_kind_next   = stq_pkg::KIND_QUEUE_FULL;
                            out_handle_next = '0;
                        end
                        else
                        begin
                            ctrl_op                  = stq_pkg::OP_INSERT;
                            in_use_next[free_handle] = 1'b1;
                            out_kind_next            = stq_pkg::KIND_INSERTED;
                            out_handle_next          = free_handle;
                        end
                    end
                    else
                    begin
                        ctrl_op         = stq_pkg::OP_DROP;
                        out_handle_next = dh_reg;
                        if (found)
                        begin
                            in_use_next[dh_reg] = 1'b0;
                            out_kind_next       = stq_pkg::KIND_DROPPED;
                        end
                        else
                        begin
                            out_kind_next = stq_pkg::KIND_NOT_FOUND;
                        end
                    end
                end
            end
            ST_FIRE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_time_next  = now_reg;
                    if (head_due)
                    begin
                        ctrl_op                           = stq_pkg::OP_FIRE;
                        in_use_next[cell_entry[0].handle] = 1'b0;
                        out_kind_next                     = stq_pkg::KIND_FIRED;
                        out_handle_next                   = cell_entry[0].handle;
                        out_tag_next                      = cell_entry[0].tag;
                        out_last_next                     = 1'b0;
                    end
                    else
                    begin
                        out_kind_next   = stq_pkg::KIND_TICK_DONE;
                        out_handle_next = '0;
                        out_tag_next    = '0;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            in_use_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            in_use_reg    <= in_use_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg <= req.cmd;
            dl_reg  <= now_reg + {{(stq_pkg::TIME_W - stq_pkg::DELAY_W){1'b0}}, req.delay};
            tag_reg <= req.event_tag;
            dh_reg  <= req.drop_handle;
        end
        out_kind_reg   <= out_kind_next;
        out_handle_reg <= out_handle_next;
        out_tag_reg    <= out_tag_next;
        out_time_reg   <= out_time_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = out_kind_reg;
    assign rsp.handle    = out_handle_reg;
    assign rsp.fired_tag = out_tag_reg;
    assign rsp.time_now  = out_time_reg;
    assign rsp.last      = out_last_reg;

`ifndef ASSERT_OFF
    a_handles_match_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(in_use_reg) == $countones(valid_vec))
        else $error("handle map and queued cells disagree");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + {{QUEUE_DEPTH{1'b0}}, 1'b1}))
        else $error("valid cells do not form a prefix");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        valid_vec[1] |-> (cell_entry[0].deadline <= cell_entry[1].deadline))
        else $error("queue head out of deadline order");

    a_tick_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIRE && state_next == ST_IDLE)
            |=> (out_valid_reg && out_kind_reg == stq_pkg::KIND_TICK_DONE && out_last_reg))
        else $error("tick finished without tick-done transfer");

    a_insert_sets_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_op == stq_pkg::OP_INSERT) |=> in_use_reg[$past(free_handle)])
        else $error("inserted handle not marked in use");
`endif

endmodule
